// ----- hdl/lru_pkg.sv -----
// lru_pkg: shared types and constants for the lru order list block
// no dependencies; compiled first
`default_nettype none

package lru_pkg;

  localparam int ID_W            = 10;
  localparam int COUNT_W         = 11;
  localparam int NUM_ENTRIES_DEF = 1024;
  localparam logic [COUNT_W-1:0] CAP_RESET = 11'd1024;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_TOUCH  = 2'd1,
    OP_REMOVE = 2'd2,
    OP_POP    = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_ABSENT  = 2'd2,
    ST_PRESENT = 2'd3
  } status_t;

  typedef struct packed {
    opcode_t           opcode;
    logic [ID_W-1:0]   entry_id;
  } item_t;

  typedef struct packed {
    status_t            status;
    logic               evicted_valid;
    logic [ID_W-1:0]    evicted_id;
    logic [COUNT_W-1:0] held_count;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic    clr_write;
    logic    accept;
    logic    unlink;
    logic    evict;
    logic    link;
    logic    finish;
    status_t status;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    opcode_t opcode;
    logic    clr_last;
    logic    in_range;
    logic    present;
    logic    is_newest;
    logic    empty;
    logic    full;
  } sts_t;

endpackage

`default_nettype wire

// ----- hdl/lru_ram.sv -----
// lru_ram: generic single write port, single read port memory, registered read
// no dependencies
`default_nettype none

module lru_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/lru_ctrl.sv -----
// lru_ctrl: sequencer for the lru order list (clear sweep, lookup, unlink, link)
// depends on lru_pkg
`default_nettype none

module lru_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output      logic          busy,
  output      logic          done,
  input  wire lru_pkg::sts_t sts,
  output      lru_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_LINK
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    cmd.status = lru_pkg::ST_OK;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_IDLE;
        unique case (sts.opcode)
          lru_pkg::OP_INSERT: begin
            if (!sts.in_range) begin
              cmd.finish = 1'b1;
              cmd.status = lru_pkg::ST_ABSENT;
            end else if (sts.present) begin
              cmd.finish = 1'b1;
              cmd.status = lru_pkg::ST_PRESENT;
            end else begin
              // full list: drop the oldest before linking
              cmd.unlink = sts.full;
              cmd.evict  = sts.full;
              state_next = S_LINK;
            end
          end
          lru_pkg::OP_TOUCH: begin
            if (!sts.present) begin
              cmd.finish = 1'b1;
              cmd.status = lru_pkg::ST_ABSENT;
            end else if (sts.is_newest) begin
              cmd.finish = 1'b1;
            end else begin
              cmd.unlink = 1'b1;
              state_next = S_LINK;
            end
          end
          lru_pkg::OP_REMOVE: begin
            cmd.finish = 1'b1;
            if (!sts.present) begin
              cmd.status = lru_pkg::ST_ABSENT;
            end else begin
              cmd.unlink = 1'b1;
            end
          end
          lru_pkg::OP_POP: begin
            cmd.finish = 1'b1;
            if (sts.empty) begin
              cmd.status = lru_pkg::ST_EMPTY;
            end else begin
              cmd.unlink = 1'b1;
              cmd.evict  = 1'b1;
            end
          end
        endcase
      end
      S_LINK: begin
        cmd.link   = 1'b1;
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.finish;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

`default_nettype wire

// ----- hdl/lru_dpath.sv -----
// lru_dpath: list registers, capacity register and the three entry memories
// depends on lru_pkg and lru_ram
`default_nettype none

module lru_dpath #(
  parameter int NUM_ENTRIES = lru_pkg::NUM_ENTRIES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire lru_pkg::item_t                  item,
  input  wire logic                            cfg_valid,
  input  wire logic [lru_pkg::COUNT_W-1:0]     cfg_data,
  input  wire lru_pkg::cmd_t                   cmd,
  output      lru_pkg::sts_t                   sts,
  output      lru_pkg::result_t                result
);

  localparam int ID_W    = lru_pkg::ID_W;
  localparam int COUNT_W = lru_pkg::COUNT_W;
  localparam int AW      = $clog2(NUM_ENTRIES);
  localparam int NUM_W   = $clog2(NUM_ENTRIES + 1);
  localparam int CMP_W   = (NUM_W > COUNT_W) ? NUM_W : COUNT_W;
  localparam logic [CMP_W-1:0] NUM_CMP  = CMP_W'(NUM_ENTRIES);
  localparam logic [AW-1:0]    LAST_ENT = AW'(NUM_ENTRIES - 1);

  lru_pkg::opcode_t   op_q;
  logic [ID_W-1:0]    id_q;
  logic [ID_W-1:0]    newest;
  logic [ID_W-1:0]    newest_next;
  logic [ID_W-1:0]    oldest;
  logic [ID_W-1:0]    oldest_next;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  logic [COUNT_W-1:0] capacity;
  logic [AW-1:0]      clr_cnt;
  logic               ev_v;
  logic               ev_v_next;
  logic [ID_W-1:0]    ev_id;
  logic [ID_W-1:0]    ev_id_next;

  logic               pres_we;
  logic [AW-1:0]      pres_waddr;
  logic               pres_wd;
  logic               pres_rd;
  logic               newer_we;
  logic [AW-1:0]      newer_waddr;
  logic [ID_W-1:0]    newer_wd;
  logic [AW-1:0]      newer_raddr;
  logic [ID_W-1:0]    newer_rd;
  logic               older_we;
  logic [AW-1:0]      older_waddr;
  logic [ID_W-1:0]    older_wd;
  logic [ID_W-1:0]    older_rd;

  logic [CMP_W-1:0]   cap_ext;
  logic [CMP_W-1:0]   cap_eff;
  logic               in_range;
  logic [ID_W-1:0]    target;

  // lookup reads are issued straight from the input at accept
  assign newer_raddr = (item.opcode == lru_pkg::OP_INSERT || item.opcode == lru_pkg::OP_POP)
                     ? AW'(oldest) : AW'(item.entry_id);

  lru_ram #(.WIDTH(1), .DEPTH(NUM_ENTRIES)) u_present (
    .clk   (clk),
    .we    (pres_we),
    .waddr (pres_waddr),
    .wdata (pres_wd),
    .re    (cmd.accept),
    .raddr (AW'(item.entry_id)),
    .rdata (pres_rd)
  );

  lru_ram #(.WIDTH(ID_W), .DEPTH(NUM_ENTRIES)) u_newer (
    .clk   (clk),
    .we    (newer_we),
    .waddr (newer_waddr),
    .wdata (newer_wd),
    .re    (cmd.accept),
    .raddr (newer_raddr),
    .rdata (newer_rd)
  );

  lru_ram #(.WIDTH(ID_W), .DEPTH(NUM_ENTRIES)) u_older (
    .clk   (clk),
    .we    (older_we),
    .waddr (older_waddr),
    .wdata (older_wd),
    .re    (cmd.accept),
    .raddr (AW'(item.entry_id)),
    .rdata (older_rd)
  );

  // capacity of zero acts as one, above the entry count acts as the entry count
  assign cap_ext  = CMP_W'(capacity);
  assign cap_eff  = (capacity == '0) ? CMP_W'(1) : ((cap_ext > NUM_CMP) ? NUM_CMP : cap_ext);
  assign in_range = CMP_W'(id_q) < NUM_CMP;
  assign target   = cmd.evict ? oldest : id_q;

  assign sts.opcode    = op_q;
  assign sts.clr_last  = (clr_cnt == LAST_ENT);
  assign sts.in_range  = in_range;
  assign sts.present   = in_range & pres_rd;
  assign sts.is_newest = (id_q == newest);
  assign sts.empty     = (count == '0);
  assign sts.full      = (CMP_W'(count) >= cap_eff) && (count != '0);

  always_comb begin
    newest_next = newest;
    oldest_next = oldest;
    count_next  = count;
    pres_we     = 1'b0;
    pres_waddr  = clr_cnt;
    pres_wd     = 1'b0;
    newer_we    = 1'b0;
    newer_waddr = AW'(older_rd);
    newer_wd    = newer_rd;
    older_we    = 1'b0;
    older_waddr = AW'(newer_rd);
    older_wd    = older_rd;

    if (cmd.clr_write) begin
      pres_we = 1'b1;
    end

    if (cmd.unlink) begin
      pres_we    = 1'b1;
      pres_waddr = AW'(target);
      count_next = count - COUNT_W'(1);
      if (count <= COUNT_W'(1)) begin
        newest_next = '0;
        oldest_next = '0;
      end else if (target == newest) begin
        newest_next = older_rd;
      end else if (target == oldest) begin
        oldest_next = newer_rd;
      end else begin
        // middle entry: join its two neighbors
        newer_we = 1'b1;
        older_we = 1'b1;
      end
    end

    if (cmd.link) begin
      pres_we     = 1'b1;
      pres_waddr  = AW'(id_q);
      pres_wd     = 1'b1;
      newest_next = id_q;
      count_next  = count + COUNT_W'(1);
      if (count == '0) begin
        oldest_next = id_q;
      end else begin
        newer_we    = 1'b1;
        newer_waddr = AW'(newest);
        newer_wd    = id_q;
        older_we    = 1'b1;
        older_waddr = AW'(id_q);
        older_wd    = newest;
      end
    end
  end

  always_comb begin
    ev_v_next  = ev_v;
    ev_id_next = ev_id;
    if (cmd.accept) begin
      ev_v_next  = 1'b0;
      ev_id_next = '0;
    end else if (cmd.unlink && cmd.evict) begin
      ev_v_next  = 1'b1;
      ev_id_next = oldest;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      newest   <= '0;
      oldest   <= '0;
      count    <= '0;
      capacity <= lru_pkg::CAP_RESET;
      clr_cnt  <= '0;
    end else begin
      newest <= newest_next;
      oldest <= oldest_next;
      count  <= count_next;
      if (cfg_valid) begin
        capacity <= cfg_data;
      end
      if (cmd.clr_write) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q <= item.opcode;
      id_q <= item.entry_id;
    end
    ev_v  <= ev_v_next;
    ev_id <= ev_id_next;
    if (cmd.finish) begin
      result.status        <= cmd.status;
      result.evicted_valid <= ev_v_next;
      result.evicted_id    <= ev_id_next;
      result.held_count    <= count_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/lru_order_list_top.sv -----
// lru_order_list_top: recency list of cache entries held as a doubly linked list
// depends on lru_pkg, lru_ctrl, lru_dpath (and lru_ram below it)
//
//  channel   handshake              payload            transfer when
//  --------  ---------------------  -----------------  -------------------------
//  item      start / busy           item (item_t)      start high, busy low
//  result    done (one-cycle pulse) result (result_t)  done high, cannot stall
//  config    cfg_valid / cfg_ready  cfg_data (11 bit)  cfg_valid and cfg_ready
//
// an item goes through a lookup, then an unlink or a reply, and an insert that
// links a new entry and a touch that moves an entry end with a link step; the link
// write is its own step, as each pointer memory has one write port and the lookup
// read is registered
// done pulses in the cycle after the last step, in which busy is already low,
// so the next item can be taken in that same cycle
// after reset the present-flag memory is cleared, one entry a cycle, with busy
// high; configuration writes are taken at any time
`default_nettype none

module lru_order_list_top #(
  parameter int NUM_ENTRIES = lru_pkg::NUM_ENTRIES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // item channel
  input  wire logic                        start,
  output      logic                        busy,
  input  wire lru_pkg::item_t              item,
  // result channel
  output      logic                        done,
  output      lru_pkg::result_t            result,
  // capacity register write
  input  wire logic                        cfg_valid,
  output      logic                        cfg_ready,
  input  wire logic [lru_pkg::COUNT_W-1:0] cfg_data
);

  lru_pkg::cmd_t cmd;
  lru_pkg::sts_t sts;

  // capacity is a plain register, a write is always taken
  assign cfg_ready = 1'b1;

  // sequencer: decides the list edit from the lookup status
  lru_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .sts   (sts),
    .cmd   (cmd)
  );

  // list head and tail, count, and the per-entry memories
  lru_dpath #(.NUM_ENTRIES(NUM_ENTRIES)) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .result    (result)
  );

endmodule

`default_nettype wire

// ----- hdl/lru_checker.sv -----
// lru_checker: port-level checks for lru_order_list_top, bound to the top level
// depends on lru_pkg and lru_order_list_top
`default_nettype none

module lru_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             start,
  input wire logic             busy,
  input wire logic             done,
  input wire lru_pkg::result_t result
);

  // an accepted item makes the block busy in the following cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after item transfer");

  // a result appears only once the block is free again
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result while busy");

  a_evict_ok: assert property (@(posedge clk) disable iff (rst)
    (done && result.evicted_valid) |-> (result.status == lru_pkg::ST_OK))
    else $error("eviction reported with error status");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == lru_pkg::ST_EMPTY) |-> (result.held_count == '0))
    else $error("empty status with nonzero count");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.held_count <= 11'd1024))
    else $error("held count beyond entry id space");

endmodule

bind lru_order_list_top lru_checker u_lru_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

`default_nettype wire
